// ===== rtl/rtph_pkg.sv =====
// Shared types and constants for the RTP header parser.
`timescale 1ns / 1ps

package rtph_pkg;

  // Result kinds carried in the kind field of a result.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_CSRC    = 3'd1;
  localparam logic [2:0] KIND_EXTHEAD = 3'd2;
  localparam logic [2:0] KIND_EXTWORD = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_BADVER  = 3'd5;
  localparam logic [2:0] KIND_PADUNK  = 3'd6;
  localparam logic [2:0] KIND_SHORT   = 3'd7;

  // Output queue depth and pointer width.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR  = 3'd1,
    PH_CSRC = 3'd2,
    PH_EXTH = 3'd3,
    PH_EXTW = 3'd4,
    PH_BODY = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       truncated;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        run_last;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  contrib_count;
    logic        marker;
    logic [6:0]  media_type;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] sync_source;
    logic [31:0] word_value;
    logic [7:0]  pad_bytes;
  } out_item_t;

  // Results produced by one parsed byte; r1 is used only when count is two.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  typedef struct packed {
    logic                 room2;
    logic [FIFO_AW:0]     level;
  } fifo_status_t;

endpackage

// ===== rtl/rtph_out_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one per cycle unless stalled.
`timescale 1ns / 1ps

module rtph_out_fifo
  import rtph_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output fifo_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_item
);

  out_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW:0]   level;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign pop       = (level != '0) && !out_stall;
  assign wr_ptr_p1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      level  <= level + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end
  end

  // Room is judged without counting this cycle's pop.
  assign status.room2 = level <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign status.level = level;
  assign out_valid    = level != '0;
  assign out_item     = mem[rd_ptr];

endmodule

// ===== rtl/rtph_parser.sv =====
// Input register and byte-wise RTP header parsing state.
`timescale 1ns / 1ps

module rtph_parser
  import rtph_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] accepted_version,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic       room2,
  output push_t      push
);

  in_item_t               in_q;
  logic                   in_q_valid;
  logic                   advance;

  phase_t                 phase, phase_next;
  logic [15:0]            offset, offset_next;
  logic [31:0]            shift, shift_next;
  logic [63:0]            hdr0, hdr0_next;
  logic [31:0]            hdr1, hdr1_next;
  logic [3:0]             csrc_left, csrc_left_next;
  logic [15:0]            ext_left, ext_left_next;
  logic [LENGTH_BITS-1:0] body, body_next;

  function automatic out_item_t make_result(logic [2:0] kind, logic with_hdr,
                                            logic [63:0] h0, logic [31:0] h1,
                                            logic [31:0] word, logic [7:0] pad);
    out_item_t   r;
    logic [63:0] g0;
    logic [31:0] g1;
    g0 = with_hdr ? h0 : 64'd0;
    g1 = with_hdr ? h1 : 32'd0;
    r.kind            = kind;
    r.run_last        = 1'b0;
    r.padding_flag    = g0[61];
    r.extension_flag  = g0[60];
    r.contrib_count   = g0[59:56];
    r.marker          = g0[55];
    r.media_type      = g0[54:48];
    r.sequence_number = g0[47:32];
    r.time_stamp      = g0[31:0];
    r.sync_source     = g1;
    r.word_value      = word;
    r.pad_bytes       = pad;
    return r;
  endfunction

  assign advance  = in_q_valid && room2;
  assign in_stall = in_q_valid && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  always_comb begin
    phase_t                 ph;
    logic                   word_done;
    logic                   padded;
    logic [7:0]             b;
    logic [7:0]             pad;
    logic                   has_word;
    out_item_t              word_res;
    out_item_t              last_res;
    logic                   has_last;

    b        = in_q.data_byte;
    has_word = 1'b0;
    has_last = 1'b0;
    word_res = make_result(KIND_HEADER, 1'b0, 64'd0, 32'd0, 32'd0, 8'd0);
    last_res = word_res;
    pad      = 8'd0;
    padded   = 1'b0;
    word_done = 1'b0;

    // A first mark restarts the packet regardless of where parsing was.
    if (in_q.first_byte) begin
      ph             = PH_HDR;
      offset_next    = '0;
      shift_next     = '0;
      hdr0_next      = '0;
      hdr1_next      = '0;
      csrc_left_next = '0;
      ext_left_next  = '0;
      body_next      = '0;
    end else begin
      ph             = phase;
      offset_next    = offset;
      shift_next     = shift;
      hdr0_next      = hdr0;
      hdr1_next      = hdr1;
      csrc_left_next = csrc_left;
      ext_left_next  = ext_left;
      body_next      = body;
    end
    phase_next = ph;

    if (ph == PH_IDLE) begin
      phase_next = PH_IDLE;
    end else if (ph == PH_HDR && offset_next == 16'd0 && b[7:6] != accepted_version) begin
      has_last   = 1'b1;
      last_res   = make_result(KIND_BADVER, 1'b0, 64'd0, 32'd0, {30'd0, b[7:6]}, 8'd0);
      phase_next = PH_IDLE;
    end else begin
      if (ph == PH_BODY) begin
        if (body_next != '1) begin
          body_next = body_next + 1'b1;
        end
      end else begin
        if (ph == PH_HDR && offset_next < 16'd8) begin
          hdr0_next = {hdr0_next[55:0], b};
        end else begin
          shift_next = {shift_next[23:0], b};
        end
        offset_next = offset_next + 16'd1;
        word_done   = offset_next[1:0] == 2'b00;

        unique case (ph)
          PH_HDR: begin
            if (offset_next == 16'd12) begin
              hdr1_next      = shift_next;
              csrc_left_next = hdr0_next[59:56];
              has_word       = 1'b1;
              word_res       = make_result(KIND_HEADER, 1'b1, hdr0_next, hdr1_next,
                                           32'd0, 8'd0);
              if (csrc_left_next != 4'd0) begin
                phase_next = PH_CSRC;
              end else begin
                phase_next = hdr0_next[60] ? PH_EXTH : PH_BODY;
              end
            end
          end
          PH_CSRC: begin
            if (word_done) begin
              has_word       = 1'b1;
              word_res       = make_result(KIND_CSRC, 1'b1, hdr0_next, hdr1_next,
                                           shift_next, 8'd0);
              csrc_left_next = csrc_left_next - 4'd1;
              if (csrc_left_next == 4'd0) begin
                phase_next = hdr0_next[60] ? PH_EXTH : PH_BODY;
              end
            end
          end
          PH_EXTH: begin
            if (word_done) begin
              has_word      = 1'b1;
              word_res      = make_result(KIND_EXTHEAD, 1'b1, hdr0_next, hdr1_next,
                                          shift_next, 8'd0);
              ext_left_next = shift_next[15:0];
              phase_next    = (ext_left_next != 16'd0) ? PH_EXTW : PH_BODY;
            end
          end
          PH_EXTW: begin
            if (word_done) begin
              has_word      = 1'b1;
              word_res      = make_result(KIND_EXTWORD, 1'b1, hdr0_next, hdr1_next,
                                          shift_next, 8'd0);
              ext_left_next = ext_left_next - 16'd1;
              if (ext_left_next == 16'd0) begin
                phase_next = PH_BODY;
              end
            end
          end
          default: begin
            phase_next = ph;
          end
        endcase
      end

      if (in_q.last_byte) begin
        has_last = 1'b1;
        if (phase_next == PH_BODY) begin
          padded = hdr0_next[61];
          if (padded && in_q.truncated) begin
            last_res = make_result(KIND_PADUNK, 1'b1, hdr0_next, hdr1_next,
                                   32'(body_next), 8'd0);
          end else if (padded) begin
            // The padding count cannot exceed the body seen so far.
            pad      = (LENGTH_BITS'(b) < body_next) ? b : body_next[7:0];
            last_res = make_result(KIND_END, 1'b1, hdr0_next, hdr1_next,
                                   32'(body_next - LENGTH_BITS'(pad)), pad);
          end else begin
            last_res = make_result(KIND_END, 1'b1, hdr0_next, hdr1_next,
                                   32'(body_next), 8'd0);
          end
        end else begin
          last_res = make_result(KIND_SHORT, phase_next != PH_HDR, hdr0_next, hdr1_next,
                                 {16'd0, offset_next}, 8'd0);
        end
        phase_next = PH_IDLE;
      end
    end

    push.count = 2'd0;
    push.r0    = word_res;
    push.r1    = last_res;
    if (advance) begin
      priority if (has_word && has_last) begin
        push.count = 2'd2;
        push.r1.run_last = 1'b1;
      end else if (has_word) begin
        push.count = 2'd1;
        push.r0.run_last = 1'b1;
      end else if (has_last) begin
        push.count = 2'd1;
        push.r0 = last_res;
        push.r0.run_last = 1'b1;
      end else begin
        push.count = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      offset    <= offset_next;
      shift     <= shift_next;
      hdr0      <= hdr0_next;
      hdr1      <= hdr1_next;
      csrc_left <= csrc_left_next;
      ext_left  <= ext_left_next;
      body      <= body_next;
    end
  end

endmodule

// ===== rtl/rtph_header_parser_top.sv =====
// Top level of the RTP header parser.
// Path: a byte request is taken into the input register and parsed from there;
// its results are written into the result queue and taken from it. Throughput:
// one byte per cycle; the four-entry result queue stalls input when fewer than two
// entries are free, and the two results of one byte are delivered one at a time.
// Reset: synchronous; the parser goes idle and accepted_version returns to 2.
`timescale 1ns / 1ps

module rtp_header_parser_top
  import rtph_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [1:0]   accepted_version;
  push_t        push;
  fifo_status_t fifo_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_version <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      accepted_version <= cfg_data;
    end
  end

  rtph_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .accepted_version (accepted_version),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .room2            (fifo_status.room2),
    .push             (push)
  );

  rtph_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .status    (fifo_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.level <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> fifo_status.room2)
    else $error("results pushed without room");

  a_pair_marks: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.r1.run_last && !push.r0.run_last)
    else $error("run_last wrong on a result pair");

  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd1 |-> push.r0.run_last)
    else $error("run_last missing on a single result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two results from one byte");

endmodule
